@@ sv/rdf_pkg.sv @@
// Shared types for the restoring divider with fraction.
// No dependencies; imported by rdf_cell and the top level.
package rdf_pkg;

  // Per-cell flow control: upstream valid and the common advance enable.
  typedef struct packed {
    logic valid;
    logic advance;
  } rdf_step_t;

endpackage

@@ sv/rdf_cell.sv @@
// One restoring division step with its pipeline register.
// Depends on rdf_pkg for the flow control struct.
module rdf_cell #(
  parameter int DIVIDEND_BITS = 32,
  parameter int DIVISOR_BITS  = 8,
  parameter int FRACTION_BITS = 8
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  rdf_pkg::rdf_step_t                        ctl_i,
  input  logic [DIVISOR_BITS:0]                     rem_i,
  input  logic [DIVISOR_BITS-1:0]                   den_i,
  input  logic [DIVIDEND_BITS+FRACTION_BITS-1:0]    word_i,
  output logic                                      valid_o,
  output logic [DIVISOR_BITS:0]                     rem_o,
  output logic [DIVISOR_BITS-1:0]                   den_o,
  output logic [DIVIDEND_BITS+FRACTION_BITS-1:0]    word_o
);
  import rdf_pkg::*;

  localparam int WordW = DIVIDEND_BITS + FRACTION_BITS;

  logic [DIVISOR_BITS:0]  rem_sh;
  logic [DIVISOR_BITS:0]  rem_d, rem_q;
  logic [DIVISOR_BITS-1:0] den_q;
  logic [WordW-1:0]       word_d, word_q;
  logic                   ge;
  logic                   valid_q;

  // Shift next bit (MSB of word) into remainder, trial subtract.
  always_comb begin
    rem_sh = {rem_i[DIVISOR_BITS-1:0], word_i[WordW-1]};
    ge     = rem_sh >= {1'b0, den_i};
    rem_d  = ge ? (rem_sh - {1'b0, den_i}) : rem_sh;
    word_d = (word_i << 1) | WordW'(ge);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctl_i.advance) begin
      valid_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.advance) begin
      rem_q  <= rem_d;
      den_q  <= den_i;
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign den_o   = den_q;
  assign word_o  = word_q;

  // Restoring invariant: remainder stays below a non-zero divisor.
  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && (den_q != '0)) |-> (rem_q < {1'b0, den_q}))
    else $error("partial remainder not below divisor");

  // A frozen cell keeps its valid flag.
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctl_i.advance |=> (valid_q == $past(valid_q)))
    else $error("cell valid changed while frozen");

  // Divisor of a live transfer travels unchanged down the chain.
  a_den_carry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.advance && ctl_i.valid) |=> (den_q == $past(den_i)))
    else $error("divisor not carried");

endmodule

@@ sv/rdf_skid.sv @@
// Output skid register decoupling the cell chain from the result stall.
// No package dependencies.
module rdf_skid #(
  parameter int WIDTH = 40
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [WIDTH-1:0] in_data_i,
  input  logic             stall_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o
);

  logic             full_d, full_q;
  logic [WIDTH-1:0] data_q;

  // Catch a result the consumer refuses; release when it takes it.
  always_comb begin
    if (full_q) begin
      full_d = stall_i;
    end else begin
      full_d = in_valid_i && stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!full_q) begin
      data_q <= in_data_i;
    end
  end

  assign valid_o = full_q || in_valid_i;
  assign data_o  = full_q ? data_q : in_data_i;
  assign full_o  = full_q;

  a_full_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q |-> valid_o)
    else $error("skid full but no valid result");

  a_fill_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full_q) |-> $past(in_valid_i && stall_i))
    else $error("skid filled without a stalled result");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full_q && !stall_i) |=> !full_q)
    else $error("skid not drained after transfer");

endmodule

@@ sv/restoring_divider_with_fraction.sv @@
// Top level of the pipelined restoring divider with fraction bits.
// Depends on rdf_pkg, rdf_cell and rdf_skid.
//
// Divides an unsigned DIVIDEND_BITS dividend by an unsigned DIVISOR_BITS
// divisor, giving the integer quotient and FRACTION_BITS fraction bits
// (floor of remainder * 2^FRACTION_BITS / divisor). The datapath is a row of
// DIVIDEND_BITS + FRACTION_BITS identical cells, one restoring step each, so
// a new transfer is taken every clock unless the output skid register is full,
// and each result passes through every cell's register in turn. A divisor of
// zero needs no special path: each trial subtract of zero succeeds, so both
// fields come out all ones. A skid register at the output holds one result
// while the consumer stalls; the input stall is that register's full flag, so
// the chain freezes only after a refused result has been parked. The partial
// remainder carries one bit more than the divisor so large divisors divide
// correctly.
module restoring_divider_with_fraction #(
  parameter int DIVIDEND_BITS = 32,
  parameter int FRACTION_BITS = 8,
  parameter int DIVISOR_BITS  = 8
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        valid_i,
  output logic                                        stall_o,
  input  logic [DIVIDEND_BITS-1:0]                    dividend_i,
  input  logic [DIVISOR_BITS-1:0]                     divisor_i,
  output logic                                        valid_o,
  input  logic                                        stall_i,
  output logic [DIVIDEND_BITS-1:0]                    quotient_o,
  output logic [(FRACTION_BITS > 0 ? FRACTION_BITS : 1)-1:0] fraction_o
);
  import rdf_pkg::*;

  localparam int Steps = DIVIDEND_BITS + FRACTION_BITS;

  logic                     stage_valid [Steps+1];
  logic [DIVISOR_BITS:0]    stage_rem   [Steps+1];
  logic [DIVISOR_BITS-1:0]  stage_den   [Steps+1];
  logic [Steps-1:0]         stage_word  [Steps+1];

  logic             skid_full;
  logic             advance;
  logic [Steps-1:0] out_word;

  // Whole chain moves together unless the skid holds a refused result.
  assign advance = !skid_full;
  assign stall_o = skid_full;

  // Chain head: empty remainder, dividend left-aligned above zero fraction bits.
  assign stage_valid[0] = valid_i;
  assign stage_rem[0]   = '0;
  assign stage_den[0]   = divisor_i;
  assign stage_word[0]  = Steps'(dividend_i) << FRACTION_BITS;

  for (genvar k = 0; k < Steps; k++) begin : g_cell
    rdf_step_t ctl;

    assign ctl.valid   = stage_valid[k];
    assign ctl.advance = advance;

    rdf_cell #(
      .DIVIDEND_BITS(DIVIDEND_BITS),
      .DIVISOR_BITS (DIVISOR_BITS),
      .FRACTION_BITS(FRACTION_BITS)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .rem_i  (stage_rem[k]),
      .den_i  (stage_den[k]),
      .word_i (stage_word[k]),
      .valid_o(stage_valid[k+1]),
      .rem_o  (stage_rem[k+1]),
      .den_o  (stage_den[k+1]),
      .word_o (stage_word[k+1])
    );
  end

  rdf_skid #(
    .WIDTH(Steps)
  ) u_skid (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(stage_valid[Steps]),
    .in_data_i (stage_word[Steps]),
    .stall_i   (stall_i),
    .valid_o   (valid_o),
    .data_o    (out_word),
    .full_o    (skid_full)
  );

  // Quotient bits sit above the fraction bits in the final word.
  assign quotient_o = DIVIDEND_BITS'(out_word >> FRACTION_BITS);

  if (FRACTION_BITS > 0) begin : g_frac
    assign fraction_o = out_word[FRACTION_BITS-1:0];
  end else begin : g_nofrac
    assign fraction_o = '0;
  end

  // Final remainder is below any non-zero divisor.
  a_final_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stage_valid[Steps] && (stage_den[Steps] != '0))
      |-> (stage_rem[Steps] < {1'b0, stage_den[Steps]}))
    else $error("final remainder not below divisor");

  // An accepted transfer enters the first cell.
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && !stall_o) |=> stage_valid[1])
    else $error("accepted transfer lost at chain head");

  // Zero divisor yields an all-ones quotient and fraction.
  a_zero_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stage_valid[Steps] && (stage_den[Steps] == '0))
      |-> (stage_word[Steps] == {Steps{1'b1}}))
    else $error("zero divisor result not all ones");

endmodule
